/* rtl/humidity_sensor_pulse_decoder_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the humidity sensor pulse decoder.
// Each macro samples on clk and is disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef HUMIDITY_SENSOR_PULSE_DECODER_ASSERT_SVH
`define HUMIDITY_SENSOR_PULSE_DECODER_ASSERT_SVH

// The condition must hold whenever the trigger holds, in the same cycle.
`define HSPD_ASSERT_SAME(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// The condition must hold in the cycle after the trigger.
`define HSPD_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

/* rtl/hspd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hspd_pkg
// Shared constants and stage-to-stage request types of the pulse decoder.
// ----------------------------------------------------------------------------
package hspd_pkg;

    // Frame geometry.
    localparam int FRAME_BITS = 40;
    localparam int BYTE_W     = 8;
    localparam int CNT_W      = 6;

    localparam logic [CNT_W-1:0]  FRAME_COUNT     = CNT_W'(FRAME_BITS);
    localparam logic [BYTE_W-1:0] THRESHOLD_RESET = 8'd100;

    // One captured pulse waiting in the input register.
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] pulse_width;
        logic              restart;
    } pulse_req_t;

    // One completed frame handed to the result stage.
    typedef struct packed {
        logic                  valid;
        logic [FRAME_BITS-1:0] bits;
    } frame_req_t;

    // Status of the frame assembler.
    typedef struct packed {
        logic             advance;
        logic [CNT_W-1:0] bit_count;
    } asm_status_t;

endpackage

/* rtl/hspd_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hspd_in_if / hspd_out_if
// Valid/ready channels for pulse requests and decoded frame results.
// ----------------------------------------------------------------------------
interface hspd_in_if;
    import hspd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] pulse_width;
    logic              restart;

    modport source (output valid, output pulse_width, output restart, input ready);
    modport sink   (input valid, input pulse_width, input restart, output ready);
endinterface

interface hspd_out_if;
    import hspd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] humidity_int;
    logic [BYTE_W-1:0] humidity_dec;
    logic [BYTE_W-1:0] temp_int;
    logic [BYTE_W-1:0] temp_dec;
    logic [BYTE_W-1:0] check_byte;
    logic              check_ok;

    modport source (
        output valid, output humidity_int, output humidity_dec, output temp_int,
        output temp_dec, output check_byte, output check_ok, input ready
    );
    modport sink (
        input valid, input humidity_int, input humidity_dec, input temp_int,
        input temp_dec, input check_byte, input check_ok, output ready
    );
endinterface

/* rtl/hspd_pulse_capture.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hspd_pulse_capture
// Input register: holds one accepted pulse request until the assembler
// consumes it.
// ----------------------------------------------------------------------------
module hspd_pulse_capture (
    input  logic                 clk,
    input  logic                 rst_n,
    hspd_in_if.sink              in_ch,
    input  hspd_pkg::asm_status_t asm_stat,
    output hspd_pkg::pulse_req_t  cap_req
);
    import hspd_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] width_reg;
    logic              restart_reg;
    logic              accept;

    // The register may refill in the same cycle its request moves on.
    assign in_ch.ready = !valid_reg || asm_stat.advance;
    assign accept      = in_ch.valid && in_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (asm_stat.advance)
        begin
            valid_next = 1'b0;
        end
    end

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            width_reg   <= in_ch.pulse_width;
            restart_reg <= in_ch.restart;
        end
    end

    assign cap_req.valid       = valid_reg;
    assign cap_req.pulse_width = width_reg;
    assign cap_req.restart     = restart_reg;

endmodule

/* rtl/hspd_frame_assembler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hspd_frame_assembler
// Slices each pulse against the threshold, shifts the bit in MSB first and
// counts bits until a full frame is collected.
// ----------------------------------------------------------------------------
module hspd_frame_assembler (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [hspd_pkg::BYTE_W-1:0]   threshold,
    input  hspd_pkg::pulse_req_t          cap_req,
    input  logic                          frame_ready,
    output hspd_pkg::frame_req_t          frame_req,
    output hspd_pkg::asm_status_t         asm_stat
);
    import hspd_pkg::*;

    logic [FRAME_BITS-1:0] frame_reg;
    logic [FRAME_BITS-1:0] frame_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [FRAME_BITS-1:0] base_bits;
    logic [CNT_W-1:0]      base_count;
    logic [FRAME_BITS-1:0] shifted;
    logic [CNT_W-1:0]      count_inc;
    logic                  bit_val;
    logic                  complete;
    logic                  advance;

    // A restart drops the partial frame before this pulse is taken.
    assign bit_val    = cap_req.pulse_width > threshold;
    assign base_bits  = cap_req.restart ? '0 : frame_reg;
    assign base_count = cap_req.restart ? '0 : count_reg;
    assign shifted    = {base_bits[FRAME_BITS-2:0], bit_val};
    assign count_inc  = base_count + CNT_W'(1);
    assign complete   = count_inc == FRAME_COUNT;

    // A completing pulse waits until the result stage can take the frame.
    assign advance = cap_req.valid && (!complete || frame_ready);

    always_comb
    begin
        frame_next = frame_reg;
        count_next = count_reg;
        if (advance)
        begin
            if (complete)
            begin
                frame_next = '0;
                count_next = '0;
            end
            else
            begin
                frame_next = shifted;
                count_next = count_inc;
            end
        end
    end

    // Frame state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            frame_reg <= frame_next;
            count_reg <= count_next;
        end
    end

    assign frame_req.valid     = cap_req.valid && complete;
    assign frame_req.bits      = shifted;
    assign asm_stat.advance    = advance;
    assign asm_stat.bit_count  = count_reg;

endmodule

/* rtl/hspd_result_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hspd_result_stage
// Splits a finished frame into bytes, checks the checksum and holds the
// result in the output register until the receiver takes it.
// ----------------------------------------------------------------------------
module hspd_result_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hspd_pkg::frame_req_t frame_req,
    output logic                 frame_ready,
    hspd_out_if.source           out_ch
);
    import hspd_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] hum_int_reg;
    logic [BYTE_W-1:0] hum_dec_reg;
    logic [BYTE_W-1:0] tmp_int_reg;
    logic [BYTE_W-1:0] tmp_dec_reg;
    logic [BYTE_W-1:0] chk_reg;
    logic              ok_reg;
    logic [BYTE_W-1:0] sum8;
    logic              load;

    // The register is free when empty or being read this cycle.
    assign frame_ready = !valid_reg || out_ch.ready;
    assign load        = frame_req.valid && frame_ready;

    // Sum of the four data bytes, kept modulo 256.
    assign sum8 = frame_req.bits[39:32] + frame_req.bits[31:24]
                + frame_req.bits[23:16] + frame_req.bits[15:8];

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            valid_next = 1'b0;
        end
    end

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hum_int_reg <= frame_req.bits[39:32];
            hum_dec_reg <= frame_req.bits[31:24];
            tmp_int_reg <= frame_req.bits[23:16];
            tmp_dec_reg <= frame_req.bits[15:8];
            chk_reg     <= frame_req.bits[7:0];
            ok_reg      <= sum8 == frame_req.bits[7:0];
        end
    end

    assign out_ch.valid        = valid_reg;
    assign out_ch.humidity_int = hum_int_reg;
    assign out_ch.humidity_dec = hum_dec_reg;
    assign out_ch.temp_int     = tmp_int_reg;
    assign out_ch.temp_dec     = tmp_dec_reg;
    assign out_ch.check_byte   = chk_reg;
    assign out_ch.check_ok     = ok_reg;

endmodule

/* rtl/humidity_sensor_pulse_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// humidity_sensor_pulse_decoder
// Decodes single-wire humidity sensor pulse widths into 40-bit frames.
// ----------------------------------------------------------------------------
// Usage:
// in_ch carries one request per captured high pulse: its width in timer ticks
// and a restart flag that drops any partial frame before the pulse is used.
// A width strictly above the threshold register is a one bit; bits enter
// MSB first. Every 40th bit produces one request on out_ch with the five
// received bytes and a checksum verdict; other pulses produce nothing.
// cfg_wen/cfg_wdata write the threshold; write it only while the block idles.
// Path: a completing pulse passes the input register, then the result
// register, and is presented on out_ch from the result register.
// Throughput: one pulse per cycle while the result register can take a
// finished frame, set by the single compare-and-shift step between the
// input register and the frame state.
// Reset clears the bit count, the frame bits and both valid flags, and sets
// the threshold to 100. When the receiver stalls, the result register holds;
// pulses that do not finish a frame keep flowing, and the pulse that would
// finish the next frame waits in the input register, so in_ch.ready drops.
// ----------------------------------------------------------------------------
`include "humidity_sensor_pulse_decoder_assert.svh"

module humidity_sensor_pulse_decoder (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wen,
    input  logic [hspd_pkg::BYTE_W-1:0] cfg_wdata,
    hspd_in_if.sink                     in_ch,
    hspd_out_if.source                  out_ch
);
    import hspd_pkg::*;

    logic [BYTE_W-1:0] threshold_reg;
    pulse_req_t        cap_req;
    frame_req_t        frame_req;
    asm_status_t       asm_stat;
    logic              frame_ready;

    // Threshold register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
        end
        else if (cfg_wen)
        begin
            threshold_reg <= cfg_wdata;
        end
    end

    hspd_pulse_capture u_capture (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .asm_stat (asm_stat),
        .cap_req  (cap_req)
    );

    hspd_frame_assembler u_assembler (
        .clk         (clk),
        .rst_n       (rst_n),
        .threshold   (threshold_reg),
        .cap_req     (cap_req),
        .frame_ready (frame_ready),
        .frame_req   (frame_req),
        .asm_stat    (asm_stat)
    );

    hspd_result_stage u_result (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_req   (frame_req),
        .frame_ready (frame_ready),
        .out_ch      (out_ch)
    );

    // The bit count never reaches a full frame; completion clears it.
    `HSPD_ASSERT_SAME(a_count_range, 1'b1, asm_stat.bit_count < FRAME_COUNT, "bit count overflow")
    // A pulse that cannot move on must still be held next cycle.
    `HSPD_ASSERT_NEXT(a_cap_hold, cap_req.valid && !asm_stat.advance, cap_req.valid, "pulse lost")
    // A frame taken by the result stage must show up on the output.
    `HSPD_ASSERT_NEXT(a_frame_out, frame_req.valid && frame_ready, out_ch.valid, "frame lost")

endmodule

/* tb/humidity_sensor_pulse_decoder_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// humidity_sensor_pulse_decoder_tb
// Drives pulse-width requests into the decoder and checks every decoded frame.
// A table of directed frames covers the width and threshold extremes,
// checksum pass, fail and wrap, and restarts with and without a partial frame.
// Random phases follow at several thresholds. Each phase mixes well-formed
// frames with random content and broken partial frames. Both channels idle
// at random. One phase holds the result channel off long enough to back the
// block up. A local decoder model predicts each frame that the table does not type.
// ----------------------------------------------------------------------------
module humidity_sensor_pulse_decoder_tb;
    import hspd_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int PULSE_TARGET  = 1450;
    localparam int HOLD_CYCLES   = 400;

    // One decoded frame, first received byte in the top bits.
    typedef struct packed {
        logic [BYTE_W-1:0] humidity_int;
        logic [BYTE_W-1:0] humidity_dec;
        logic [BYTE_W-1:0] temp_int;
        logic [BYTE_W-1:0] temp_dec;
        logic [BYTE_W-1:0] check_byte;
        logic              check_ok;
    } reading_t;

    // One directed frame: threshold, payload, leading junk pulses and widths.
    typedef struct {
        logic [BYTE_W-1:0]     thr;
        logic [FRAME_BITS-1:0] bits;
        int                    lead;
        logic                  rs;
        logic [BYTE_W-1:0]     w_one;
        logic [BYTE_W-1:0]     w_zero;
        logic                  typed;
        logic                  ok;
    } frame_case_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wen;
    logic [BYTE_W-1:0]    cfg_wdata;

    hspd_in_if  in_ch ();
    hspd_out_if out_ch ();

    // Local decoder state.
    logic [BYTE_W-1:0]     thr_model;
    logic [FRAME_BITS-1:0] shift_model;
    logic [CNT_W-1:0]      count_model;

    reading_t frames_due [$];
    reading_t typed_want;
    bit       use_typed = 1'b0;
    bit       calm = 1'b0;
    bit       hold_req = 1'b0;
    int       hold_left = 0;
    int       mismatches = 0;
    int       pulses_sent = 0;
    int       frames_checked = 0;
    int       thr_writes = 0;
    int       cycle_count = 0;

    // Directed frames. Rows marked typed carry their expected checksum verdict.
    frame_case_t frame_cases [11] = '{
        '{8'd100, 40'h00_00_00_00_00,  0, 1'b0, 8'd255, 8'd0,   1'b1, 1'b1},
        '{8'd100, 40'hFF_FF_FF_FF_FF,  0, 1'b0, 8'd255, 8'd0,   1'b1, 1'b0},
        '{8'd100, 40'h32_00_19_05_50,  0, 1'b0, 8'd101, 8'd100, 1'b1, 1'b1},
        '{8'd100, 40'h32_00_19_05_51,  0, 1'b1, 8'd200, 8'd50,  1'b1, 1'b0},
        '{8'd100, 40'hFF_FF_FF_FF_FC,  0, 1'b0, 8'd255, 8'd0,   1'b1, 1'b1},
        '{8'd100, 40'h11_22_33_44_AA,  3, 1'b0, 8'd180, 8'd20,  1'b0, 1'b0},
        '{8'd100, 40'h3C_05_16_02_59, 17, 1'b1, 8'd150, 8'd10,  1'b1, 1'b1},
        '{8'd100, 40'hA5_5A_C3_3C_00, 39, 1'b1, 8'd255, 8'd0,   1'b1, 1'b0},
        '{8'd0,   40'h80_01_40_02_C3,  0, 1'b0, 8'd1,   8'd0,   1'b1, 1'b1},
        '{8'd255, 40'h12_34_56_78_9A,  0, 1'b0, 8'd255, 8'd0,   1'b0, 1'b0},
        '{8'd254, 40'h01_02_03_04_0A,  0, 1'b0, 8'd255, 8'd254, 1'b1, 1'b1}
    };

    humidity_sensor_pulse_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // 50 MHz clock.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Run-length guard.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Decode one pulse; returns 1 when it completes a frame.
    function automatic bit decode_pulse(input logic [BYTE_W-1:0] w, input logic rs,
                                        output reading_t r);
        logic [BYTE_W-1:0] sum8;
        r = '0;
        if (rs)
        begin
            count_model = '0;
            shift_model = '0;
        end
        shift_model = {shift_model[FRAME_BITS-2:0], (w > thr_model)};
        count_model = count_model + 1'b1;
        if (count_model != FRAME_COUNT)
            return 1'b0;
        r.humidity_int = shift_model[39:32];
        r.humidity_dec = shift_model[31:24];
        r.temp_int     = shift_model[23:16];
        r.temp_dec     = shift_model[15:8];
        r.check_byte   = shift_model[7:0];
        sum8 = r.humidity_int + r.humidity_dec + r.temp_int + r.temp_dec;
        r.check_ok = (sum8 == r.check_byte);
        count_model = '0;
        shift_model = '0;
        return 1'b1;
    endfunction

    // Idle length: mostly none, sometimes short, rarely a long pause.
    function automatic int pick_gap();
        int roll;
        if (calm)
            return 0;
        roll = $urandom_range(99);
        if (roll < 65)
            return 0;
        if (roll < 95)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Pulse width that decodes to the wanted bit under the current threshold.
    function automatic logic [BYTE_W-1:0] width_for(input logic b);
        int roll;
        roll = $urandom_range(7);
        if (b)
        begin
            // A threshold of 255 leaves no width that decodes as one.
            if (thr_model == 8'd255 || roll == 0)
                return 8'd255;
            if (roll == 1)
                return thr_model + 1'b1;
            return 8'($urandom_range(255, thr_model + 1));
        end
        if (roll == 0)
            return 8'd0;
        if (roll == 1)
            return thr_model;
        return 8'($urandom_range(thr_model, 0));
    endfunction

    // Field compare with a report on mismatch.
    function automatic void check_field(input string name, input logic [BYTE_W-1:0] want,
                                        input logic [BYTE_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Offer one pulse request, wait for acceptance, then idle at random.
    task automatic send_pulse(input logic [BYTE_W-1:0] w, input logic rs);
        reading_t r;
        int       gap;
        in_ch.valid       <= 1'b1;
        in_ch.pulse_width <= w;
        in_ch.restart     <= rs;
        do
            @(posedge clk);
        while (!in_ch.ready);
        if (decode_pulse(w, rs, r))
            frames_due.push_back(use_typed ? typed_want : r);
        pulses_sent++;
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Stop offering and wait until every expected frame has been seen.
    task automatic drain_frames();
        in_ch.valid <= 1'b0;
        while (frames_due.size() != 0)
            @(negedge clk);
        // Let a pulse still in flight settle before the block is touched.
        repeat (4) @(negedge clk);
    endtask

    task automatic write_threshold(input logic [BYTE_W-1:0] v);
        drain_frames();
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_wen <= 1'b0;
        thr_model = v;
        thr_writes++;
    endtask

    // A well-formed frame with random bytes, half of them with a good checksum.
    task automatic send_frame();
        logic [BYTE_W-1:0]     b [4];
        logic [BYTE_W-1:0]     sum8;
        logic [FRAME_BITS-1:0] bits;
        logic                  rs;
        bit                    extreme;
        extreme = ($urandom_range(5) == 0);
        foreach (b[j])
            b[j] = extreme ? ($urandom_range(1) ? 8'hFF : 8'h00) : 8'($urandom_range(255));
        sum8 = b[0] + b[1] + b[2] + b[3];
        bits = {b[0], b[1], b[2], b[3],
                ($urandom_range(1) ? sum8 : 8'($urandom_range(255)))};
        // Restart is needed only when a partial frame is pending.
        rs = (count_model != 0) ? 1'b1 : 1'($urandom_range(1));
        for (int k = FRAME_BITS - 1; k >= 0; k--)
            send_pulse(width_for(bits[k]), (k == FRAME_BITS - 1) ? rs : 1'b0);
    endtask

    // A broken frame: a run of random pulses with the odd restart.
    task automatic send_noise();
        int n;
        n = $urandom_range(FRAME_BITS - 1, 1);
        repeat (n)
            send_pulse(8'($urandom_range(255)), ($urandom_range(15) == 0));
    endtask

    // Result side: random stalls, plus a long hold-off on request.
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // Compare each accepted frame request with the oldest expectation.
    always @(posedge clk)
    begin
        reading_t got;
        reading_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = {out_ch.humidity_int, out_ch.humidity_dec, out_ch.temp_int,
                   out_ch.temp_dec, out_ch.check_byte, out_ch.check_ok};
            if (frames_due.size() == 0)
            begin
                $display("%0t: unexpected frame, expected none, got %h", $time, got);
                mismatches++;
            end
            else
            begin
                want = frames_due.pop_front();
                check_field("humidity_int", want.humidity_int, got.humidity_int);
                check_field("humidity_dec", want.humidity_dec, got.humidity_dec);
                check_field("temp_int", want.temp_int, got.temp_int);
                check_field("temp_dec", want.temp_dec, got.temp_dec);
                check_field("check_byte", want.check_byte, got.check_byte);
                check_field("check_ok", 8'(want.check_ok), 8'(got.check_ok));
            end
            frames_checked++;
        end
    end

    // Main sequence.
    initial
    begin
        int phase;
        int n_thr;
        in_ch.valid       = 1'b0;
        in_ch.pulse_width = '0;
        in_ch.restart     = 1'b0;
        out_ch.ready      = 1'b0;
        cfg_wen           = 1'b0;
        cfg_wdata         = '0;
        rst_n             = 1'b0;
        thr_model         = THRESHOLD_RESET;
        shift_model       = '0;
        count_model       = '0;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed frames from the table.
        foreach (frame_cases[i])
        begin
            if (frame_cases[i].thr !== thr_model)
                write_threshold(frame_cases[i].thr);
            repeat (frame_cases[i].lead)
                send_pulse(8'($urandom_range(255)), 1'b0);
            use_typed  = frame_cases[i].typed;
            typed_want = {frame_cases[i].bits, frame_cases[i].ok};
            for (int k = FRAME_BITS - 1; k >= 0; k--)
                send_pulse(frame_cases[i].bits[k] ? frame_cases[i].w_one : frame_cases[i].w_zero,
                           (k == FRAME_BITS - 1) ? frame_cases[i].rs : 1'b0);
            use_typed = 1'b0;
        end
        drain_frames();

        // Random phases, each at its own threshold.
        phase = 0;
        while (pulses_sent < PULSE_TARGET)
        begin
            case (phase % 6)
                0:       n_thr = 0;
                1:       n_thr = 255;
                2:       n_thr = 100;
                3:       n_thr = 1;
                4:       n_thr = 254;
                default: n_thr = $urandom_range(255);
            endcase
            write_threshold(8'(n_thr));

            if (phase == 2)
            begin
                // Hold the result side off while frames keep coming, so the
                // block backs up and stalls its input.
                calm     = 1'b1;
                hold_req = 1'b1;
                repeat (3) send_frame();
                calm = 1'b0;
                drain_frames();
            end

            calm = (phase % 5 == 3);
            repeat (6)
            begin
                if ($urandom_range(99) < 15)
                    send_noise();
                else
                    send_frame();
            end
            calm = 1'b0;
            phase++;
        end

        drain_frames();
        repeat (10) @(negedge clk);
        $display("Sent %0d pulses, checked %0d frames over %0d threshold writes (%0d random phases)",
                 pulses_sent, frames_checked, thr_writes, phase);
        if (mismatches == 0 && frames_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/hspd_pkg.sv
rtl/hspd_if.sv
rtl/hspd_pulse_capture.sv
rtl/hspd_frame_assembler.sv
rtl/hspd_result_stage.sv
rtl/humidity_sensor_pulse_decoder.sv
tb/humidity_sensor_pulse_decoder_tb.sv
